/* design/uvd_pkg.sv */
// Shared types and constants for the UTF-8 validating decoder.
package uvd_pkg;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_START     = 3'd1,
        ERR_CONT      = 3'd2,
        ERR_END       = 3'd3,
        ERR_OVERLONG  = 3'd4,
        ERR_CODEPOINT = 3'd5
    } t_err;

    localparam logic [20:0] MAX_1BYTE    = 21'h00007F;
    localparam logic [20:0] MAX_2BYTE    = 21'h0007FF;
    localparam logic [20:0] MAX_3BYTE    = 21'h00FFFF;
    localparam logic [20:0] SURR_LO      = 21'h00D800;
    localparam logic [20:0] SURR_HI      = 21'h00DFFF;
    localparam logic [20:0] MAX_SCALAR   = 21'h10FFFF;

    // Decoder state carried between bytes.
    typedef struct packed {
        logic [2:0]  seq_len;
        logic [1:0]  taken;
        logic [20:0] acc;
        logic        held_err;
        logic [7:0]  held_bad;
        logic        discard;
    } t_state;

    // One result transaction.
    typedef struct packed {
        logic [20:0] code_point;
        t_err        error_code;
        logic [7:0]  offending_byte;
        logic        closes_string;
    } t_result;

endpackage

/* design/uvd_step.sv */
// Single-byte decode step: next state and optional result.
module uvd_step (
    input  uvd_pkg::t_state  i_state,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output uvd_pkg::t_state  o_state,
    output logic             o_emit,
    output uvd_pkg::t_result o_result
);
    import uvd_pkg::*;

    logic        held_err_n;
    logic [7:0]  held_bad_n;
    logic [20:0] acc_n;
    logic [2:0]  taken_n;
    logic [2:0]  min_len;
    t_err        err;
    logic [20:0] cp;
    logic [7:0]  bad;

    always_comb begin
        o_state    = i_state;
        o_emit     = 1'b0;
        err        = ERR_OK;
        cp         = '0;
        bad        = '0;
        held_err_n = i_state.held_err;
        held_bad_n = i_state.held_bad;
        acc_n      = {i_state.acc[14:0], i_byte[5:0]};
        taken_n    = {1'b0, i_state.taken} + 3'd1;
        if (acc_n <= MAX_1BYTE) begin
            min_len = 3'd1;
        end else if (acc_n <= MAX_2BYTE) begin
            min_len = 3'd2;
        end else if (acc_n <= MAX_3BYTE) begin
            min_len = 3'd3;
        end else begin
            min_len = 3'd4;
        end

        if (i_state.discard) begin
            // drop bytes until the string ends
            if (i_last) begin
                o_state = '0;
            end
        end else if (i_state.seq_len == 3'd0) begin
            if (i_byte[7] == 1'b0) begin
                o_emit = 1'b1;
                cp     = {13'd0, i_byte};
            end else if (i_byte[7:5] == 3'b110 || i_byte[7:4] == 4'b1110 ||
                         i_byte[7:3] == 5'b11110) begin
                if (i_last) begin
                    o_emit = 1'b1;
                    err    = ERR_END;
                end else begin
                    o_state.taken    = 2'd1;
                    o_state.held_err = 1'b0;
                    o_state.held_bad = '0;
                    if (i_byte[7:5] == 3'b110) begin
                        o_state.seq_len = 3'd2;
                        o_state.acc     = {16'd0, i_byte[4:0]};
                    end else if (i_byte[7:4] == 4'b1110) begin
                        o_state.seq_len = 3'd3;
                        o_state.acc     = {17'd0, i_byte[3:0]};
                    end else begin
                        o_state.seq_len = 3'd4;
                        o_state.acc     = {18'd0, i_byte[2:0]};
                    end
                end
            end else begin
                o_emit = 1'b1;
                err    = ERR_START;
                bad    = i_byte;
            end
        end else begin
            // keep only the first bad continuation byte
            if (i_byte[7:6] != 2'b10 && !i_state.held_err) begin
                held_err_n = 1'b1;
                held_bad_n = i_byte;
            end
            o_state.acc      = acc_n;
            o_state.held_err = held_err_n;
            o_state.held_bad = held_bad_n;
            if (taken_n < i_state.seq_len) begin
                if (i_last) begin
                    o_emit = 1'b1;
                    err    = ERR_END;
                end else begin
                    o_state.taken = taken_n[1:0];
                end
            end else begin
                o_emit = 1'b1;
                if (held_err_n) begin
                    err = ERR_CONT;
                    bad = held_bad_n;
                end else if ((acc_n >= SURR_LO && acc_n <= SURR_HI) ||
                             acc_n > MAX_SCALAR) begin
                    err = ERR_CODEPOINT;
                end else if (i_state.seq_len > min_len) begin
                    err = ERR_OVERLONG;
                end else begin
                    cp = acc_n;
                end
            end
        end

        if (o_emit) begin
            o_state         = '0;
            o_state.discard = (err != ERR_OK) && !i_last;
        end

        o_result.code_point     = cp;
        o_result.error_code     = err;
        o_result.offending_byte = bad;
        o_result.closes_string  = (err != ERR_OK) || i_last;
    end

endmodule

/* design/utf8_validating_decoder.sv */
// Top level of the streaming strict UTF-8 decoder.
//
// Input channel: one byte per transaction on i_byte_value, with
// i_end_of_string marking the last byte of a string. A transaction completes
// when i_in_valid is high and o_in_stall is low.
// Output channel: one decoded code point or error report per transaction on
// o_code_point / o_error_code / o_offending_byte / o_closes_string, taken when
// o_out_valid is high and i_out_stall is low.
// Each byte is decoded in the cycle it is accepted; its result, if any, is
// registered in the output register, or in the skid register while the
// output register still holds an untaken result. Throughput is one byte per
// cycle while o_in_stall is low: the decode step is a single pass of shallow
// logic against the state register. A two-entry output buffer (output
// register plus skid register) lets a new byte enter while a finished result
// still waits; o_in_stall rises only when both entries are full, i.e. after
// the receiver has stalled while another result was produced.
// Synchronous reset (i_rst_n low) returns the decoder to idle, clears the
// discard mode and empties the output buffer.
// After an error the block reports once and silently drops the remaining
// bytes of the string, up to and including the end-of-string byte.
module utf8_validating_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_value,
    input  logic        i_end_of_string,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [20:0] o_code_point,
    output logic [2:0]  o_error_code,
    output logic [7:0]  o_offending_byte,
    output logic        o_closes_string
);
    import uvd_pkg::*;

    t_state  r_st;
    t_state  n_st;
    logic    step_emit;
    t_result step_res;

    t_result r_out;
    logic    r_out_valid;
    t_result r_skd;
    logic    r_skd_valid;

    logic    in_fire;
    logic    out_fire;
    logic    res_valid;

    assign o_in_stall = r_skd_valid;
    assign in_fire    = i_in_valid && !r_skd_valid;
    assign out_fire   = r_out_valid && !i_out_stall;
    assign res_valid  = in_fire && step_emit;

    uvd_step u_step (
        .i_state  (r_st),
        .i_byte   (i_byte_value),
        .i_last   (i_end_of_string),
        .o_state  (n_st),
        .o_emit   (step_emit),
        .o_result (step_res)
    );

    // Decoder state: advance only on an accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (in_fire) begin
            r_st <= n_st;
        end
    end

    // Output buffer control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (r_skd_valid) begin
            // input is stalled: move the skid entry forward once drained
            if (out_fire) begin
                r_skd_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (r_out_valid && !out_fire) begin
                r_skd_valid <= 1'b1;
            end
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output buffer payload.
    always_ff @(posedge i_clk) begin
        if (r_skd_valid) begin
            if (out_fire) begin
                r_out <= r_skd;
            end
        end else if (res_valid) begin
            if (r_out_valid && !out_fire) begin
                r_skd <= step_res;
            end else begin
                r_out <= step_res;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_code_point     = r_out.code_point;
    assign o_error_code     = r_out.error_code;
    assign o_offending_byte = r_out.offending_byte;
    assign o_closes_string  = r_out.closes_string;

    // The skid entry is only ever occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry valid with empty output register");

    // An error report carries no code point and always closes the string.
    a_err_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code != ERR_OK) |->
        (r_out.code_point == 21'd0 && r_out.closes_string))
        else $error("error result with code point or open string");

    // While in discard mode the sequence position is always idle.
    a_discard_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.discard |-> (r_st.seq_len == 3'd0 && r_st.taken == 2'd0))
        else $error("discarding while a sequence is in progress");

    // The skid fills only when the receiver stalled a waiting result.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skd_valid ##1 r_skd_valid) |-> $past(r_out_valid && i_out_stall))
        else $error("skid filled without an output stall");

endmodule

/* sim/tb_top.sv */
// Self-checking testbench for the streaming strict UTF-8 decoder.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uvd_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned RANDOM_BYTES = 400;
    localparam int unsigned HOLD_CYCLES = 60;

    // Track decoder state per byte and keep the code points and error reports still owed.
    class utf8_scoreboard;
        logic [2:0]  seq_len;
        logic [1:0]  taken;
        logic [20:0] acc;
        logic        held_err;
        logic [7:0]  held_bad;
        logic        discard;
        t_result     owed_q[$];
        int unsigned mismatches;
        int unsigned results_seen;
        int unsigned error_reports;

        function new();
            clear_sequence();
            discard = 1'b0;
            mismatches = 0;
            results_seen = 0;
            error_reports = 0;
        endfunction

        function void clear_sequence();
            seq_len = 3'd0;
            taken = 2'd0;
            acc = '0;
            held_err = 1'b0;
            held_bad = 8'd0;
        endfunction

        function void owe_result(logic [20:0] cp, t_err err, logic [7:0] bad, logic last);
            t_result r;
            r.code_point = cp;
            r.error_code = err;
            r.offending_byte = bad;
            r.closes_string = (err != ERR_OK) || last;
            owed_q.push_back(r);
            clear_sequence();
            discard = (err != ERR_OK) && !last;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            logic [2:0] next_taken;
            logic [2:0] min_len;
            if (discard) begin
                if (last) begin
                    clear_sequence();
                    discard = 1'b0;
                end
                return;
            end
            if (seq_len == 3'd0) begin
                if (!b[7]) begin
                    owe_result({13'd0, b}, ERR_OK, 8'd0, last);
                    return;
                end
                if (b[7:5] == 3'b110) begin
                    seq_len = 3'd2;
                    acc = {16'd0, b[4:0]};
                end else if (b[7:4] == 4'b1110) begin
                    seq_len = 3'd3;
                    acc = {17'd0, b[3:0]};
                end else if (b[7:3] == 5'b11110) begin
                    seq_len = 3'd4;
                    acc = {18'd0, b[2:0]};
                end else begin
                    owe_result('0, ERR_START, b, last);
                    return;
                end
                if (last) begin
                    owe_result('0, ERR_END, 8'd0, 1'b1);
                    return;
                end
                taken = 2'd1;
                held_err = 1'b0;
                held_bad = 8'd0;
                return;
            end
            // Keep only the first bad continuation byte.
            if (b[7:6] != 2'b10 && !held_err) begin
                held_err = 1'b1;
                held_bad = b;
            end
            acc = {acc[14:0], b[5:0]};
            next_taken = {1'b0, taken} + 3'd1;
            if (next_taken < seq_len) begin
                if (last)
                    owe_result('0, ERR_END, 8'd0, 1'b1);
                else
                    taken = next_taken[1:0];
                return;
            end
            if (held_err) begin
                owe_result('0, ERR_CONT, held_bad, last);
                return;
            end
            // Range check outranks the overlong check.
            if ((acc >= SURR_LO && acc <= SURR_HI) || acc > MAX_SCALAR) begin
                owe_result('0, ERR_CODEPOINT, 8'd0, last);
                return;
            end
            min_len = (acc <= MAX_1BYTE) ? 3'd1 : (acc <= MAX_2BYTE) ? 3'd2 :
                      (acc <= MAX_3BYTE) ? 3'd3 : 3'd4;
            if (seq_len > min_len)
                owe_result('0, ERR_OVERLONG, 8'd0, last);
            else
                owe_result(acc, ERR_OK, 8'd0, last);
        endfunction

        function void check_result(t_result got);
            t_result want;
            results_seen++;
            if (got.error_code != ERR_OK)
                error_reports++;
            if (owed_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cp=%h err=%0d bad=%h close=%b",
                             got.code_point, got.error_code, got.offending_byte,
                             got.closes_string);
                return;
            end
            want = owed_q.pop_front();
            if (got.code_point !== want.code_point || got.error_code !== want.error_code ||
                got.offending_byte !== want.offending_byte ||
                got.closes_string !== want.closes_string) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: expected cp=%h err=%0d bad=%h close=%b, ",
                           want.code_point, want.error_code, want.offending_byte,
                           want.closes_string);
                    $display("got cp=%h err=%0d bad=%h close=%b",
                             got.code_point, got.error_code, got.offending_byte,
                             got.closes_string);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_byte_value;
    logic        i_end_of_string;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [20:0] o_code_point;
    logic [2:0]  o_error_code;
    logic [7:0]  o_offending_byte;
    logic        o_closes_string;

    utf8_scoreboard sb = new();
    t_result        seen;
    int unsigned    cycles = 0;
    int unsigned    bytes_sent = 0;
    int unsigned    random_bytes = 0;
    bit             calm = 1'b0;

    utf8_validating_decoder uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_byte_value     (i_byte_value),
        .i_end_of_string  (i_end_of_string),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_code_point     (o_code_point),
        .o_error_code     (o_error_code),
        .o_offending_byte (o_offending_byte),
        .o_closes_string  (o_closes_string)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Abort a hung run; the limit is far above the slowest legal run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycles, sb.owed_q.size());
            $display("utf8_validating_decoder regression: fail");
            $finish;
        end
    end

    // Sample both channels at the edge, before any update of this edge lands.
    // Check the output first: a result leaving now always stems from a byte taken
    // at an earlier edge, so the order keeps the prediction in step.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.code_point = o_code_point;
            seen.error_code = t_err'(o_error_code);
            seen.offending_byte = o_offending_byte;
            seen.closes_string = o_closes_string;
            sb.check_result(seen);
        end
        if (i_rst_n && i_in_valid && !o_in_stall)
            sb.note_byte(i_byte_value, i_end_of_string);
    end

    // Output side: stall at random, stay quiet during the calm stretch, and hold
    // off once for a long stretch so that the output buffer fills and the input stalls.
    initial begin : receiver
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!hold_done && random_bytes >= 60) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < 12);
            end
        end
    end

    // Offer one byte, idle at random first, then hold it until the transaction
    // completes. Valid stays high between back-to-back bytes.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!calm && $urandom_range(99) < 12) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_value <= b;
        i_end_of_string <= last;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
    endtask

    // Build one string: mostly well-formed characters, some raw encodings of
    // random 21-bit values (overlong, surrogate, out of range), some stray bytes,
    // and now and then a string cut short, possibly in the middle of a sequence.
    task automatic send_random_string();
        logic [7:0]  str_q[$];
        logic [20:0] cp;
        int unsigned pick;
        int unsigned len;
        repeat ($urandom_range(6, 1)) begin
            pick = $urandom_range(99);
            len = $urandom_range(4, 1);
            if (pick < 60) begin
                case (len)
                    1: cp = 21'($urandom_range(32'h7F));
                    2: cp = 21'($urandom_range(32'h7FF, 32'h80));
                    3: begin
                        cp = 21'($urandom_range(32'hFFFF, 32'h800));
                        // Move a surrogate out of the reserved range.
                        if (cp >= SURR_LO && cp <= SURR_HI)
                            cp ^= 21'h4000;
                    end
                    default: cp = 21'($urandom_range(32'h10FFFF, 32'h10000));
                endcase
            end else begin
                cp = 21'($urandom);
            end
            if (pick >= 88) begin
                str_q.push_back(8'($urandom));
            end else begin
                case (len)
                    1: str_q.push_back({1'b0, cp[6:0]});
                    2: begin
                        str_q.push_back({3'b110, cp[10:6]});
                        str_q.push_back({2'b10, cp[5:0]});
                    end
                    3: begin
                        str_q.push_back({4'b1110, cp[15:12]});
                        str_q.push_back({2'b10, cp[11:6]});
                        str_q.push_back({2'b10, cp[5:0]});
                    end
                    default: begin
                        str_q.push_back({5'b11110, cp[20:18]});
                        str_q.push_back({2'b10, cp[17:12]});
                        str_q.push_back({2'b10, cp[11:6]});
                        str_q.push_back({2'b10, cp[5:0]});
                    end
                endcase
            end
        end
        if ($urandom_range(9) == 0 && str_q.size() > 1)
            repeat ($urandom_range(str_q.size() - 1, 1)) void'(str_q.pop_back());
        foreach (str_q[k])
            send_byte(str_q[k], k == str_q.size() - 1);
        random_bytes += str_q.size();
    endtask

    initial begin : stimulus
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_byte_value = 8'd0;
        i_end_of_string = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ASCII extremes, the first one inside a longer string.
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
        // Bad start that itself ends the string: no discarding follows.
        send_byte(8'h80, 1'b1);
        // Bad start mid-string: drop the rest through the end byte.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h41, 1'b1);
        // Smallest two-byte value.
        send_byte(8'hC2, 1'b0);
        send_byte(8'h80, 1'b1);
        // Largest scalar value.
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        // Overlong two-byte NUL.
        send_byte(8'hC0, 1'b0);
        send_byte(8'h80, 1'b1);
        // Surrogate in three bytes.
        send_byte(8'hED, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b1);
        // Surrogate that is also overlong: the code point error wins.
        send_byte(8'hF0, 1'b0);
        send_byte(8'h8D, 1'b0);
        send_byte(8'hA0, 1'b0);
        send_byte(8'h80, 1'b1);
        // Bad continuation, then the string ends early: unexpected end wins.
        send_byte(8'hE2, 1'b0);
        send_byte(8'h41, 1'b1);
        // Bad continuation reported once the length is reached.
        send_byte(8'hE2, 1'b0);
        send_byte(8'h28, 1'b0);
        send_byte(8'hA1, 1'b1);
        // Lead byte on the last byte of a string.
        send_byte(8'hE0, 1'b1);

        while (random_bytes < RANDOM_BYTES) begin
            calm = (random_bytes >= 150 && random_bytes < 250);
            send_random_string();
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain, then give a late stray result time to show up.
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("sent %0d bytes (%0d random); checked %0d results, %0d of them error reports",
                 bytes_sent, random_bytes, sb.results_seen, sb.error_reports);
        $display("mismatches: %0d, results still owed: %0d", sb.mismatches, sb.owed_q.size());
        if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
            $display("utf8_validating_decoder regression: pass");
        end else begin
            $display("utf8_validating_decoder regression: fail");
        end
        $finish;
    end

endmodule
